// ===== hdl/hmve_pkg.sv =====
// ---------------------------------------------------------------------------
// hmve_pkg
// Shared types, constants and helpers of the complex matrix-vector engine.
// ---------------------------------------------------------------------------
package hmve_pkg;

   localparam int MAX_DIM   = 8;
   localparam int IDX_W     = 3;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int SIZE_W    = 4;
   localparam int VAL_W     = 16;
   localparam int ACC_W     = 40;
   localparam int PROD_W    = 2 * VAL_W;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_SET   = 3'd1,
      OP_READ  = 3'd2,
      OP_ADJ   = 3'd3,
      OP_CHECK = 3'd4,
      OP_VEC   = 3'd5
   } opcode_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
   } entry_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
   } sum_type;

   // negate with the most negative code going to the most positive one
   function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         r = -v;
      end
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] sext(input logic signed [VAL_W-1:0] v);
      return {{(ACC_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

endpackage

// ===== hdl/hmve_req_if.sv =====
// ---------------------------------------------------------------------------
// hmve_req_if
// Request channel: one operation beat with valid/ready.
// ---------------------------------------------------------------------------
interface hmve_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        opcode;
   logic [2:0]        row_index;
   logic [2:0]        col_index;
   logic signed [15:0] value_re;
   logic signed [15:0] value_im;
   logic              vector_last;

   modport source (output valid, opcode, row_index, col_index, value_re, value_im,
                   vector_last, input ready);
   modport sink   (input valid, opcode, row_index, col_index, value_re, value_im,
                   vector_last, output ready);
endinterface

// ===== hdl/hmve_rsp_if.sv =====
// ---------------------------------------------------------------------------
// hmve_rsp_if
// Response channel: one result beat with valid/ready.
// ---------------------------------------------------------------------------
interface hmve_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] result_re;
   logic signed [39:0] result_im;
   logic               is_hermitian;
   logic [2:0]         result_row;
   logic               result_last;

   modport source (output valid, result_re, result_im, is_hermitian, result_row,
                   result_last, input ready);
   modport sink   (input valid, result_re, result_im, is_hermitian, result_row,
                   result_last, output ready);
endinterface

// ===== hdl/hmve_store.sv =====
// ---------------------------------------------------------------------------
// hmve_store
// Matrix entry memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module hmve_store
   import hmve_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  entry_type         wdata,
   input  logic [ADDR_W-1:0] raddr_a,
   input  logic [ADDR_W-1:0] raddr_b,
   output entry_type         rdata_a,
   output entry_type         rdata_b
);

   entry_type mem [DEPTH];
   entry_type rdata_a_ff;
   entry_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== hdl/hmve_cmac.sv =====
// ---------------------------------------------------------------------------
// hmve_cmac
// Shared complex multiply-accumulate unit with the per-row saturating sums.
// ---------------------------------------------------------------------------
module hmve_cmac
   import hmve_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             mac_en,
   input  logic [IDX_W-1:0] mac_row,
   input  entry_type        mat,
   input  entry_type        vec,
   input  logic             clear,
   input  logic [IDX_W-1:0] rd_row,
   output sum_type          rd_sum
);

   localparam logic signed [ACC_W:0] SAT_MAX = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W:0] SAT_MIN = {2'b11, {(ACC_W-1){1'b0}}};

   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                     p_valid_ff;
   logic [IDX_W-1:0]         p_row_ff;
   sum_type                  acc_ff [MAX_DIM];
   sum_type                  acc_in;
   logic signed [ACC_W:0]    sum_re, sum_im;

   always_ff @(posedge clock) begin
      p_rr_ff  <= mat.re * vec.re;
      p_ii_ff  <= mat.im * vec.im;
      p_ri_ff  <= mat.re * vec.im;
      p_ir_ff  <= mat.im * vec.re;
      p_row_ff <= mac_row;
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= mac_en;
      end
   end

   // products stay within 32 bits, so one extra bit covers the sum
   always_comb begin
      sum_re = {acc_ff[p_row_ff].re[ACC_W-1], acc_ff[p_row_ff].re}
             + (ACC_W+1)'(p_rr_ff) - (ACC_W+1)'(p_ii_ff);
      sum_im = {acc_ff[p_row_ff].im[ACC_W-1], acc_ff[p_row_ff].im}
             + (ACC_W+1)'(p_ri_ff) + (ACC_W+1)'(p_ir_ff);
      if (sum_re > SAT_MAX) begin
         acc_in.re = SAT_MAX[ACC_W-1:0];
      end else if (sum_re < SAT_MIN) begin
         acc_in.re = SAT_MIN[ACC_W-1:0];
      end else begin
         acc_in.re = sum_re[ACC_W-1:0];
      end
      if (sum_im > SAT_MAX) begin
         acc_in.im = SAT_MAX[ACC_W-1:0];
      end else if (sum_im < SAT_MIN) begin
         acc_in.im = SAT_MIN[ACC_W-1:0];
      end else begin
         acc_in.im = sum_im[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int k = 0; k < MAX_DIM; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (p_valid_ff) begin
         acc_ff[p_row_ff] <= acc_in;
      end
   end

   assign rd_sum = acc_ff[rd_row];

endmodule

// ===== hdl/hermitian_matrix_vector_engine.sv =====
// ---------------------------------------------------------------------------
// hermitian_matrix_vector_engine
// Complex matrix store with element access, Hermitian check and
// matrix-vector accumulation through one shared complex MAC.
// ---------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_bus   in         valid/ready      opcode, indexes, value, vector_last
//  rsp_bus   out        valid/ready      result, is_hermitian, row, last
//  csr       in         csr_we           csr_wdata = matrix_size
//
//  load writes directly; set writes the entry, then its conjugate mirror;
//  read registers the stored entry and holds the result until taken; check
//  compares all n*n pairs; vector element: one row per cycle through the
//  MAC, then a drain; the last element then sends n beats out.
//  reset clears control and the row sums; the matrix store is not cleared.
//  req_bus.ready is low while an item is in work or its results wait.
// ---------------------------------------------------------------------------
module hermitian_matrix_vector_engine
   import hmve_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hmve_req_if.sink          req_bus,
   hmve_rsp_if.source        rsp_bus,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MIRROR, ST_READ, ST_RESP, ST_HERM, ST_HWAIT, ST_MAC, ST_DRAIN, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [SIZE_W-1:0]  n;
   logic [IDX_W-1:0]   r_ff, r_in, c_ff, c_in;
   entry_type          v_ff, v_in;
   logic               last_ff, last_in, adj_ff, adj_in, inside_ff, inside_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic               herm_ff, herm_in, cmp_ff, cmp_in;
   logic               rdv_ff, rdv_in;
   logic [IDX_W-1:0]   rdrow_ff, rdrow_in;
   logic               drain_ff, drain_in;
   logic [SIZE_W-1:0]  e_ff, e_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic               rsp_herm_ff, rsp_herm_in, rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0]   rsp_row_ff, rsp_row_in;

   logic               accept, take, in_range, mismatch, clear;
   logic               we;
   logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
   entry_type          wdata, q_a, q_b;
   sum_type            acc_sum;
   opcode_type         op;

   hmve_store u_store (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (q_a),
      .rdata_b (q_b)
   );

   hmve_cmac u_cmac (
      .clock   (clock),
      .reset   (reset),
      .mac_en  (rdv_ff),
      .mac_row (rdrow_ff),
      .mat     (q_a),
      .vec     (v_ff),
      .clear   (clear),
      .rd_row  (e_ff[IDX_W-1:0]),
      .rd_sum  (acc_sum)
   );

   always_comb begin
      if (size_ff == '0) begin
         n = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         n = SIZE_W'(MAX_DIM);
      end else begin
         n = size_ff;
      end
   end

   assign op       = opcode_type'(req_bus.opcode);
   assign accept   = req_bus.valid && req_bus.ready;
   assign take     = rsp_valid_ff && rsp_bus.ready;
   assign in_range = ({1'b0, req_bus.row_index} < n) && ({1'b0, req_bus.col_index} < n);
   assign mismatch = cmp_ff && !((q_a.re == q_b.re) && (q_a.im == neg_sat(q_b.im)));

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      adj_in       = adj_ff;
      inside_in    = inside_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      herm_in      = herm_ff & ~mismatch;
      cmp_in       = 1'b0;
      rdv_in       = 1'b0;
      rdrow_in     = rdrow_ff;
      drain_in     = drain_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_herm_in  = rsp_herm_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      clear        = 1'b0;
      we           = 1'b0;
      waddr        = {req_bus.row_index, req_bus.col_index};
      wdata        = {req_bus.value_re, req_bus.value_im};
      raddr_a      = {i_ff, j_ff};
      raddr_b      = {j_ff, i_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r_in      = req_bus.row_index;
               c_in      = req_bus.col_index;
               v_in      = {req_bus.value_re, req_bus.value_im};
               last_in   = req_bus.vector_last;
               adj_in    = (op == OP_ADJ);
               inside_in = in_range;
               i_in      = '0;
               j_in      = '0;
               e_in      = '0;
               case (op)
                  OP_LOAD: begin
                     we = in_range;
                  end
                  OP_SET: begin
                     we = in_range;
                     if (in_range) begin
                        state_in = ST_MIRROR;
                     end
                  end
                  OP_READ: begin
                     raddr_a  = {req_bus.row_index, req_bus.col_index};
                     state_in = ST_READ;
                  end
                  OP_ADJ: begin
                     raddr_a  = {req_bus.col_index, req_bus.row_index};
                     state_in = ST_READ;
                  end
                  OP_CHECK: begin
                     herm_in  = 1'b1;
                     state_in = ST_HERM;
                  end
                  OP_VEC: begin
                     if ({1'b0, req_bus.col_index} < n) begin
                        state_in = ST_MAC;
                     end else if (req_bus.vector_last) begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MIRROR: begin
            we       = 1'b1;
            waddr    = {c_ff, r_ff};
            wdata    = {v_ff.re, neg_sat(v_ff.im)};
            state_in = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_re_in    = inside_ff ? sext(q_a.re) : '0;
            rsp_im_in    = inside_ff ? sext(adj_ff ? neg_sat(q_a.im) : q_a.im) : '0;
            rsp_herm_in  = 1'b0;
            rsp_row_in   = r_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (take) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_HERM: begin
            cmp_in = 1'b1;
            if ({1'b0, j_ff} == n - SIZE_W'(1)) begin
               j_in = '0;
               if ({1'b0, i_ff} == n - SIZE_W'(1)) begin
                  state_in = ST_HWAIT;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_HWAIT: begin
            // last pair compares this cycle
            rsp_valid_in = 1'b1;
            rsp_re_in    = '0;
            rsp_im_in    = '0;
            rsp_herm_in  = herm_ff & ~mismatch;
            rsp_row_in   = '0;
            rsp_last_in  = 1'b1;
            state_in     = ST_RESP;
         end
         ST_MAC: begin
            raddr_a  = {i_ff, c_ff};
            rdv_in   = 1'b1;
            rdrow_in = i_ff;
            drain_in = 1'b0;
            if ({1'b0, i_ff} == n - SIZE_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // waits for the product and accumulate registers
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (take && rsp_last_ff) begin
               rsp_valid_in = 1'b0;
               clear        = 1'b1;
               state_in     = ST_IDLE;
            end else if (!rsp_valid_ff || take) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = acc_sum.re;
               rsp_im_in    = acc_sum.im;
               rsp_herm_in  = 1'b0;
               rsp_row_in   = e_ff[IDX_W-1:0];
               rsp_last_in  = (e_ff + SIZE_W'(1) == n);
               e_in         = e_ff + SIZE_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_W'(MAX_DIM);
         herm_ff      <= 1'b0;
         cmp_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         drain_ff     <= 1'b0;
         e_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         herm_ff      <= herm_in;
         cmp_ff       <= cmp_in;
         rdv_ff       <= rdv_in;
         drain_ff     <= drain_in;
         e_ff         <= e_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff        <= r_in;
      c_ff        <= c_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      adj_ff      <= adj_in;
      inside_ff   <= inside_in;
      rdrow_ff    <= rdrow_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_herm_ff <= rsp_herm_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_re    = rsp_re_ff;
   assign rsp_bus.result_im    = rsp_im_ff;
   assign rsp_bus.is_hermitian = rsp_herm_ff;
   assign rsp_bus.result_row   = rsp_row_ff;
   assign rsp_bus.result_last  = rsp_last_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_valid_ff)
      else $error("request taken while a result is pending");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff == ST_IDLE) || (state_ff == ST_MIRROR))
      else $error("store written outside a load or set");

   a_emit_last_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_valid_ff && rsp_last_ff
      |-> {1'b0, rsp_row_ff} == n - SIZE_W'(1))
      else $error("final row sum on the wrong row");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      clear |=> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("row sums cleared while results remain");

endmodule
